/* rtl/core/eigs_pkg.sv */
// Shared types for the even interval group splitter.
// Holds the result status codes, controller states and the
// command/status structs between controller and datapath.
package eigs_pkg;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_END_BELOW  = 2'd1,
    ST_BAD_COUNT  = 2'd2,
    ST_BAD_SELECT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_WALK,
    S_ERR
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item, seed divider and walk
    logic div_step;   // one restoring divide step
    logic walk_step;  // advance to the next group
    logic emit_err;   // write an error result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    status_t err;        // error code of the captured item
    logic    div_done;   // current divide step is the final one
    logic    walk_emit;  // current group produces a result
    logic    walk_last;  // current group is the final result
    logic    out_free;   // output register can take a result this cycle
  } stat_t;

endpackage

/* rtl/core/even_interval_group_splitter.sv */
// Sequence: accept, a check state, INDEX_WIDTH bit-serial divide steps, then the group walk.
// The walk advances one group per cycle while the output register can take each result.
// An error item skips the divide and the walk and gives a single error result.
// The divider is bit-serial and the group walk keeps a running group start.
// One item at a time; while m_axis_tready is low, a pending result holds back further results.
// Reset (rst, synchronous, active high) returns to idle and drops m_axis_tvalid.
module even_interval_group_splitter #(
  parameter int INDEX_WIDTH = 32,
  parameter int MAX_GROUPS  = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // interval_start, interval_end, group_count[6:0], group_select[5:0], zero pad
  input  logic [((2*INDEX_WIDTH+13+7)/8)*8-1:0]  s_axis_tdata,
  // action
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // group_number[5:0], group_start, group_end, element count, zero pad
  output logic [((3*INDEX_WIDTH+6+7)/8)*8-1:0]   m_axis_tdata,
  // status
  output logic [1:0]                             m_axis_tuser,
  output logic                                   m_axis_tlast
);

  eigs_pkg::cmd_t  cmd;
  eigs_pkg::stat_t stat;

  eigs_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  eigs_dp #(
    .INDEX_WIDTH (INDEX_WIDTH),
    .MAX_GROUPS  (MAX_GROUPS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd           (cmd),
    .stat          (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk_step && stat.walk_emit) || cmd.emit_err |-> stat.out_free)
    else $error("result written over a pending output item");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.load, cmd.div_step, cmd.walk_step, cmd.emit_err}) <= 1)
    else $error("controller issued more than one command");

  a_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.load == (s_axis_tvalid && s_axis_tready))
    else $error("capture does not match input handshake");

endmodule

/* rtl/core/eigs_ctrl.sv */
// Controller state machine for the even interval group splitter.
// Sequences capture, check, divide and group walk.
// Depends on eigs_pkg.
module eigs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  eigs_pkg::stat_t stat,
  output eigs_pkg::cmd_t  cmd
);

  eigs_pkg::state_t state;
  eigs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eigs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      eigs_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load   = 1'b1;
          state_next = eigs_pkg::S_CHECK;
        end
      end
      eigs_pkg::S_CHECK: begin
        if (stat.err != eigs_pkg::ST_OK) begin
          state_next = eigs_pkg::S_ERR;
        end else begin
          state_next = eigs_pkg::S_DIV;
        end
      end
      eigs_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = eigs_pkg::S_WALK;
        end
      end
      eigs_pkg::S_WALK: begin
        // groups before the selected one are skipped without waiting on output
        if (!stat.walk_emit || stat.out_free) begin
          cmd.walk_step = 1'b1;
          if (stat.walk_emit && stat.walk_last) begin
            state_next = eigs_pkg::S_IDLE;
          end
        end
      end
      eigs_pkg::S_ERR: begin
        if (stat.out_free) begin
          cmd.emit_err = 1'b1;
          state_next   = eigs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = eigs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/eigs_dp.sv */
// Datapath for the even interval group splitter: input capture, error check,
// bit-serial divider, running group start and the output register.
// Depends on eigs_pkg.
module eigs_dp #(
  parameter int INDEX_WIDTH = 32,
  parameter int MAX_GROUPS  = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [((2*INDEX_WIDTH+13+7)/8)*8-1:0]  s_axis_tdata,
  input  logic                                   s_axis_tuser,
  input  eigs_pkg::cmd_t                         cmd,
  output eigs_pkg::stat_t                        stat,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((3*INDEX_WIDTH+6+7)/8)*8-1:0]   m_axis_tdata,
  output logic [1:0]                             m_axis_tuser,
  output logic                                   m_axis_tlast
);

  localparam int IW  = INDEX_WIDTH;
  localparam int CW  = $clog2(INDEX_WIDTH);
  localparam int ODW = ((3*INDEX_WIDTH+6+7)/8)*8;

  logic [IW-1:0] in_start;
  logic [IW-1:0] in_end;
  logic [6:0]    in_count;
  logic [5:0]    in_sel;
  eigs_pkg::status_t err_in;

  assign in_start = s_axis_tdata[IW-1:0];
  assign in_end   = s_axis_tdata[2*IW-1:IW];
  assign in_count = s_axis_tdata[2*IW+6:2*IW];
  assign in_sel   = s_axis_tdata[2*IW+12:2*IW+7];

  always_comb begin
    if (in_end < in_start) begin
      err_in = eigs_pkg::ST_END_BELOW;
    end else if (in_count == 7'd0 || in_count > 7'(MAX_GROUPS)) begin
      err_in = eigs_pkg::ST_BAD_COUNT;
    end else if (s_axis_tuser && {1'b0, in_sel} >= in_count) begin
      err_in = eigs_pkg::ST_BAD_SELECT;
    end else begin
      err_in = eigs_pkg::ST_OK;
    end
  end

  // captured item
  logic              act;
  logic [6:0]        count;
  logic [5:0]        sel;
  eigs_pkg::status_t err;

  // divider: dq shifts the length out and the quotient in
  logic [IW-1:0] dq;
  logic [6:0]    rem;
  logic [CW-1:0] cnt;
  logic [7:0]    trial;
  logic          qbit;

  // group walk
  logic [IW-1:0] cur_start;
  logic [IW-1:0] walk_end;
  logic [5:0]    g;
  logic          extra;

  // output register
  logic [5:0]        onum;
  logic [IW-1:0]     ostart;
  logic [IW-1:0]     oend;
  logic [IW-1:0]     osize;
  eigs_pkg::status_t ostatus;
  logic              olast;
  logic              out_wr;

  assign trial = {rem, dq[IW-1]};
  assign qbit  = (trial >= {1'b0, count});

  assign extra    = ({1'b0, g} < rem);
  assign walk_end = cur_start + dq + IW'(extra);

  assign stat.err       = err;
  assign stat.div_done  = (cnt == CW'(IW-1));
  assign stat.walk_emit = !act || (g == sel);
  assign stat.walk_last = act ? (g == sel) : (({1'b0, g} + 7'd1) == count);
  assign stat.out_free  = !m_axis_tvalid || m_axis_tready;

  assign out_wr = (cmd.walk_step && stat.walk_emit) || cmd.emit_err;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act       <= s_axis_tuser;
      count     <= in_count;
      sel       <= in_sel;
      err       <= err_in;
      dq        <= in_end - in_start;
      rem       <= '0;
      cnt       <= '0;
      cur_start <= in_start;
      g         <= '0;
    end else begin
      if (cmd.div_step) begin
        rem <= qbit ? 7'(trial - {1'b0, count}) : trial[6:0];
        dq  <= {dq[IW-2:0], qbit};
        cnt <= cnt + CW'(1);
      end
      if (cmd.walk_step) begin
        cur_start <= walk_end;
        g         <= g + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step && stat.walk_emit) begin
      onum    <= g;
      ostart  <= cur_start;
      oend    <= walk_end;
      osize   <= walk_end - cur_start;
      ostatus <= eigs_pkg::ST_OK;
      olast   <= stat.walk_last;
    end else if (cmd.emit_err) begin
      onum    <= '0;
      ostart  <= '0;
      oend    <= '0;
      osize   <= '0;
      ostatus <= err;
      olast   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_wr) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = ODW'({osize, oend, ostart, onum});
  assign m_axis_tuser = ostatus;
  assign m_axis_tlast = olast;

  a_err_result_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && ostatus != eigs_pkg::ST_OK |->
      olast && onum == '0 && ostart == '0 && oend == '0)
    else $error("error result carries group data or lacks last");

  a_rem_below_count: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_step |-> rem < count)
    else $error("remainder not below group count during walk");

  a_walk_after_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_step |-> err == eigs_pkg::ST_OK && count != 7'd0)
    else $error("group walk on an item flagged as error");

endmodule
